FILE: sv/ctb_pkg.sv
// Shared types and constants for the countdown timer bank.
// Holds the request and result payloads and the controller/datapath command bundle.
`default_nettype none

package ctb_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int ADDR_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_SET = 2'd1;
  localparam logic [1:0] OP_GET = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  timer_index;
    logic [15:0] seconds;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  new_index;
    logic [15:0] value;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic mem_rd;
    logic rd_walk;
    logic mem_wr;
    logic wr_dec;
    logic walk_inc;
    logic out_load;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       walk_last;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/ctb_ctrl.sv
// Controller state machine of the countdown timer bank.
// Depends on ctb_pkg for the command and status bundles and operation codes.
`default_nettype none

module ctb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ctb_pkg::sts_t sts,
  output ctb_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RD   = 5'b00100,
    S_WR   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          ctb_pkg::OP_SET: begin
            cmd.mem_wr = 1'b1;
            state_nxt = S_DONE;
          end
          ctb_pkg::OP_GET: begin
            cmd.mem_rd = 1'b1;
            state_nxt = S_DONE;
          end
          ctb_pkg::OP_TICK: begin
            state_nxt = sts.cnt_zero ? S_DONE : S_RD;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_walk = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.wr_dec = 1'b1;
        cmd.walk_inc = 1'b1;
        state_nxt = sts.walk_last ? S_DONE : S_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/ctb_dp.sv
// Datapath of the countdown timer bank: timer store, allocation count, tick walk
// pointer and the output register. Depends on ctb_pkg.
`default_nettype none

module ctb_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ctb_pkg::req_t in_data,
  input  wire ctb_pkg::cmd_t cmd,
  output ctb_pkg::sts_t      sts,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ctb_pkg::rsp_t      out_data
);

  localparam int AW = ctb_pkg::ADDR_W;
  localparam int CW = ctb_pkg::CNT_W;

  logic [15:0]                      mem [ctb_pkg::TIMER_SLOTS];
  logic [ctb_pkg::TIMER_SLOTS-1:0]  vld_r;
  ctb_pkg::req_t                    req_r;
  logic [CW-1:0]                    cnt_r;
  logic [CW-1:0]                    walk_r;
  logic [15:0]                      rdata_r;
  logic                             out_valid_r;
  ctb_pkg::rsp_t                    out_r;

  logic [AW-1:0] req_addr;
  logic [AW-1:0] mem_addr;
  logic [15:0]   wdata;
  logic          wr_en;
  logic          in_range;
  logic          full;
  ctb_pkg::rsp_t rsp;

  assign req_addr = AW'(req_r.timer_index);
  assign in_range = (32'(req_r.timer_index) < ctb_pkg::TIMER_SLOTS);
  assign full     = (cnt_r == CW'(ctb_pkg::TIMER_SLOTS));

  assign mem_addr = cmd.rd_walk || cmd.wr_dec ? walk_r[AW-1:0] : req_addr;
  assign wdata    = cmd.wr_dec ? (rdata_r - 16'd1) : req_r.seconds;
  // A set writes only inside the table; a tick step leaves zero timers alone.
  assign wr_en    = cmd.mem_wr && (cmd.wr_dec ? (rdata_r != 16'd0) : in_range);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mem_addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= vld_r[mem_addr] ? mem[mem_addr] : 16'd0;
    end
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r <= rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      cnt_r       <= '0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[mem_addr] <= 1'b1;
      end
      if (cmd.out_load && req_r.op == ctb_pkg::OP_ALLOC && !full) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.load_req) begin
        walk_r <= '0;
      end else if (cmd.walk_inc) begin
        walk_r <= walk_r + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp = '0;
    case (req_r.op)
      ctb_pkg::OP_ALLOC: begin
        if (full) begin
          rsp.status = ctb_pkg::ST_FULL;
        end else begin
          rsp.new_index = 4'(cnt_r);
        end
      end
      ctb_pkg::OP_SET: begin
        if (!in_range) begin
          rsp.status = ctb_pkg::ST_RANGE;
        end
      end
      ctb_pkg::OP_GET: begin
        if (!in_range) begin
          rsp.status = ctb_pkg::ST_RANGE;
        end else begin
          rsp.value = rdata_r;
        end
      end
      default: begin
        rsp.status = ctb_pkg::ST_OK;
      end
    endcase
  end

  assign sts.op        = req_r.op;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.walk_last = ((walk_r + CW'(1)) == cnt_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: sv/countdown_timer_bank.sv
// Countdown timer bank: allocate, set, get and tick requests, one result each.
// Allocate, set and get go from execute straight to done; tick first walks the allocated timers
// with a read-then-write step per timer over the single store port.
// One request is in work at a time; the next is taken while a result waits in the output register.
// Synchronous active-low reset clears the store (per-entry valid bits) and the allocation count.
`default_nettype none

module countdown_timer_bank (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ctb_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ctb_pkg::rsp_t      out_data
);

  ctb_pkg::cmd_t cmd;
  ctb_pkg::sts_t sts;

  ctb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: sv/ctb_checker.sv
// Port-level checks for the countdown timer bank, attached by bind.
// Depends on ctb_pkg for the payload types and status codes.
`default_nettype none

module ctb_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire ctb_pkg::rsp_t out_data
);

  // Only one request is in work, so an accepted transaction stalls the input next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ctb_pkg::ST_RANGE)
    else $error("undefined status code");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ctb_pkg::ST_OK |->
      out_data.new_index == 4'd0 && out_data.value == 16'd0)
    else $error("error result carries data");

  a_full_is_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ctb_pkg::ST_FULL |-> out_data.value == 16'd0)
    else $error("full status with a value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind countdown_timer_bank ctb_checker u_ctb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: tb/tb_countdown_timer_bank.sv
// Self-checking testbench for countdown_timer_bank: directed and random requests,
// checked against an in-bench model of the timer table. Depends on ctb_pkg.
`default_nettype none

module tb_countdown_timer_bank;
  import ctb_pkg::*;

  localparam int HOLDOFF_CYCLES = 80;
  localparam int DRAIN_CYCLES   = 40;   // longest tick walk plus margin
  localparam int STUCK_LIMIT    = 2000;
  localparam int REPORT_LIMIT   = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  countdown_timer_bank dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the timer table.
  logic [15:0] model_timers [TIMER_SLOTS];
  int unsigned model_alloc_cnt = 0;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned holdoff_req_cnt = 0;
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;

  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned checked_total = 0;
  int unsigned full_replies = 0;
  int unsigned op_counts [4] = '{0, 0, 0, 0};
  int unsigned fail_cnt = 0;
  int unsigned stuck_cycles = 0;
  logic in_fire = 1'b0;

  function automatic rsp_t apply_timer_request(req_t r);
    rsp_t rsp;
    rsp = '0;
    rsp.status = ST_OK;
    case (r.op)
      OP_ALLOC: begin
        if (model_alloc_cnt >= TIMER_SLOTS) begin
          rsp.status = ST_FULL;
        end else begin
          rsp.new_index = model_alloc_cnt[3:0];
          model_alloc_cnt++;
        end
      end
      OP_SET: begin
        if (r.timer_index >= TIMER_SLOTS) rsp.status = ST_RANGE;
        else model_timers[r.timer_index] = r.seconds;
      end
      OP_GET: begin
        if (r.timer_index >= TIMER_SLOTS) rsp.status = ST_RANGE;
        else rsp.value = model_timers[r.timer_index];
      end
      default: begin
        // Only allocated timers count down, and a timer at zero stays there.
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (i < model_alloc_cnt && model_timers[i] != 16'd0) begin
            model_timers[i] = model_timers[i] - 16'd1;
          end
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic void queue_request(logic [1:0] op, logic [3:0] idx, logic [15:0] secs);
    req_t r;
    r.op = op;
    r.timer_index = idx;
    r.seconds = secs;
    pending_reqs.push_back(r);
    queued_total++;
  endfunction

  function automatic void queue_random_requests(int unsigned count, int unsigned alloc_pct);
    int unsigned pick;
    logic [1:0] op;
    logic [15:0] secs;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct) op = OP_ALLOC;
      else if (pick < alloc_pct + 30) op = OP_SET;
      else if (pick < alloc_pct + 62) op = OP_GET;
      else op = OP_TICK;
      // Small loads let ticks reach zero; wide ones exercise every bit.
      case ($urandom_range(3))
        0: secs = 16'($urandom_range(4));
        1: secs = 16'($urandom_range(40));
        2: secs = 16'($urandom);
        default: secs = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
      queue_request(op, 4'($urandom_range(15)), secs);
    end
  endfunction

  task automatic note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic wait_for_drain();
    while (accepted_total != queued_total || expected_rsps.size() != 0) @(negedge clk);
  endtask

  // Request driver: a held transaction stays put until it is taken.
  always @(negedge clk) begin
    if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (rst_n && pending_reqs.size() != 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data <= pending_reqs.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (holdoff_seen != holdoff_req_cnt) begin
      holdoff_seen <= holdoff_req_cnt;
      holdoff_left <= HOLDOFF_CYCLES;
      out_stall <= 1'b1;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        expected_rsps.push_back(apply_timer_request(in_data));
        accepted_total++;
        op_counts[in_data.op]++;
      end
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          note_failure($sformatf("unexpected result status=%0d new_index=%0d value=%h",
                                 out_data.status, out_data.new_index, out_data.value));
        end else begin
          want = expected_rsps.pop_front();
          checked_total++;
          if (want.status == ST_FULL) full_replies++;
          if (out_data.status !== want.status || out_data.new_index !== want.new_index ||
              out_data.value !== want.value) begin
            note_failure($sformatf({"result %0d: expected status=%0d new_index=%0d value=%h,",
                                    " got status=%0d new_index=%0d value=%h"},
                                   checked_total, want.status, want.new_index, want.value,
                                   out_data.status, out_data.new_index, out_data.value));
          end
        end
      end
      if (in_fire || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 STUCK_LIMIT, expected_rsps.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < TIMER_SLOTS; i++) model_timers[i] = 16'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset contents, unallocated slots ignored by tick, zero floor.
    queue_request(OP_GET, 4'd0, 16'h0000);
    queue_request(OP_GET, 4'd15, 16'hFFFF);
    queue_request(OP_SET, 4'd15, 16'hFFFF);
    queue_request(OP_SET, 4'd0, 16'h0001);
    queue_request(OP_SET, 4'd10, 16'hAAAA);
    queue_request(OP_SET, 4'd5, 16'h5555);
    queue_request(OP_TICK, 4'd15, 16'hFFFF);
    queue_request(OP_GET, 4'd15, 16'h0000);
    queue_request(OP_GET, 4'd0, 16'h0000);
    queue_request(OP_GET, 4'd10, 16'h0000);
    queue_request(OP_ALLOC, 4'd15, 16'hFFFF);
    queue_request(OP_ALLOC, 4'd0, 16'h0000);
    queue_request(OP_TICK, 4'd0, 16'h0000);
    queue_request(OP_TICK, 4'd0, 16'h0000);
    queue_request(OP_GET, 4'd0, 16'h0000);
    queue_request(OP_GET, 4'd1, 16'h0000);
    queue_request(OP_GET, 4'd5, 16'h0000);
    queue_request(OP_SET, 4'd1, 16'hFFFF);
    queue_request(OP_TICK, 4'd0, 16'h0000);
    queue_request(OP_GET, 4'd1, 16'h0000);
    queue_request(OP_GET, 4'd15, 16'h0000);
    queue_request(OP_GET, 4'd10, 16'h0000);
    wait_for_drain();

    // The receiver holds off while requests keep coming, so the block backs up.
    queue_random_requests(200, 8);
    holdoff_req_cnt++;
    wait_for_drain();

    send_idle_pct = 69;
    queue_random_requests(250, 6);
    wait_for_drain();

    send_idle_pct = 0;
    stall_pct = 69;
    queue_random_requests(250, 6);
    wait_for_drain();

    send_idle_pct = 11;
    stall_pct = 11;
    queue_random_requests(230, 6);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_rsps.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_rsps.size()));
    end

    $display("Covered %0d requests: %0d allocate, %0d set, %0d get, %0d tick.",
             accepted_total, op_counts[OP_ALLOC], op_counts[OP_SET], op_counts[OP_GET],
             op_counts[OP_TICK]);
    $display("Checked %0d results, %0d of them table-full replies; %0d failures.",
             checked_total, full_replies, fail_cnt);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
